// ===== rtl/mlpm_pkg.sv =====
// Shared types, codes and constants for the motor link poll master.
package mlpm_pkg;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_BYTE = 1'b1;

  localparam logic KIND_TX     = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  localparam logic [1:0] CFG_POLL_INTERVAL = 2'd0;
  localparam logic [1:0] CFG_REPLY_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_MISS_LIMIT    = 2'd2;

  localparam logic [1:0] RQ_STATUS  = 2'd0;
  localparam logic [1:0] RQ_SPEED   = 2'd1;
  localparam logic [1:0] RQ_CURRENT = 2'd2;
  localparam logic [1:0] RQ_BATTERY = 2'd3;

  localparam logic [7:0] REQ_HEAD     = 8'h11;
  localparam logic [7:0] SEL_STATUS   = 8'h08;
  localparam logic [7:0] SEL_SPEED    = 8'h20;
  localparam logic [7:0] SEL_CURRENT  = 8'h0A;
  localparam logic [7:0] SEL_BATTERY  = 8'h11;
  localparam logic [7:0] SPEED_OFFSET = 8'h20;
  localparam logic [7:0] STATUS_BRAKE = 8'h03;
  localparam logic [7:0] STATUS_PEDAL = 8'h01;
  localparam logic [7:0] MISS_MAX     = 8'hFF;

  localparam logic [15:0] RST_POLL_INTERVAL = 16'd120;
  localparam logic [15:0] RST_REPLY_TIMEOUT = 16'd200;
  localparam logic [7:0]  RST_MISS_LIMIT    = 8'd12;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic        ok;
    logic        brake;
    logic        pedaling;
    logic [7:0]  current_half_amps;
    logic [15:0] wheel_rpm;
    logic [7:0]  battery_pct;
    logic        link_up;
    logic [31:0] last_reply_time;
  } beat_t;

  function automatic logic [7:0] sel_byte(input logic [1:0] rq);
    logic [7:0] s;
    unique case (rq)
      RQ_STATUS:  s = SEL_STATUS;
      RQ_SPEED:   s = SEL_SPEED;
      RQ_CURRENT: s = SEL_CURRENT;
      default:    s = SEL_BATTERY;
    endcase
    return s;
  endfunction

  function automatic logic [2:0] reply_len(input logic [1:0] rq);
    logic [2:0] n;
    unique case (rq)
      RQ_STATUS: n = 3'd1;
      RQ_SPEED:  n = 3'd3;
      default:   n = 3'd2;
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/mlpm_core.sv =====
// Poll state, reply collection and decode; produces up to two result beats per item.
module mlpm_core #(
  parameter int TIME_BITS = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step_en,
  input  logic           in_cmd,
  input  logic [7:0]     in_rx_byte,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [15:0]    cfg_wdata,
  output logic [1:0]     push_cnt,
  output mlpm_pkg::beat_t beat0,
  output mlpm_pkg::beat_t beat1
);
  import mlpm_pkg::*;

  logic [15:0] interval_r, timeout_r;
  logic [7:0]  limit_r;

  logic [TIME_BITS-1:0] time_now_r, time_now_nxt;
  logic [TIME_BITS-1:0] last_poll_r, last_poll_nxt;
  logic [3:0]  round_r, round_nxt;
  logic [7:0]  miss_r, miss_nxt;
  logic        waiting_r, waiting_nxt;
  logic [1:0]  req_kind_r, req_kind_nxt;
  logic [1:0]  bytes_got_r, bytes_got_nxt;
  logic [7:0]  reply_bytes_r [2];
  logic        brake_r, brake_nxt;
  logic        pedal_r, pedal_nxt;
  logic [7:0]  current_r, current_nxt;
  logic [15:0] rpm_r, rpm_nxt;
  logic [7:0]  battery_r, battery_nxt;
  logic        link_r, link_nxt;
  logic [31:0] reply_time_r, reply_time_nxt;

  logic [TIME_BITS-1:0] time_inc, elapsed;
  logic [2:0]  count;
  logic [7:0]  miss_inc, speed_sum;
  logic        rb_we, fin, good;

  assign time_inc  = time_now_r + TIME_BITS'(1);
  assign elapsed   = time_inc - last_poll_r;
  assign count     = {1'b0, bytes_got_r} + 3'd1;
  assign miss_inc  = (miss_r != MISS_MAX) ? miss_r + 8'd1 : miss_r;
  assign speed_sum = reply_bytes_r[0] + reply_bytes_r[1] + SPEED_OFFSET;

  always_comb begin
    time_now_nxt   = time_now_r;
    last_poll_nxt  = last_poll_r;
    round_nxt      = round_r;
    miss_nxt       = miss_r;
    waiting_nxt    = waiting_r;
    req_kind_nxt   = req_kind_r;
    bytes_got_nxt  = bytes_got_r;
    brake_nxt      = brake_r;
    pedal_nxt      = pedal_r;
    current_nxt    = current_r;
    rpm_nxt        = rpm_r;
    battery_nxt    = battery_r;
    link_nxt       = link_r;
    reply_time_nxt = reply_time_r;
    push_cnt       = 2'd0;
    beat0          = '0;
    beat1          = '0;
    rb_we          = 1'b0;
    fin            = 1'b0;
    good           = 1'b0;

    if (step_en) begin
      if (in_cmd == CMD_BYTE) begin
        if (waiting_r) begin
          rb_we = !bytes_got_r[1];
          if (count < reply_len(req_kind_r)) begin
            bytes_got_nxt = count[1:0];
          end else begin
            fin = 1'b1;
            unique case (req_kind_r)
              RQ_STATUS: begin
                brake_nxt = (in_rx_byte == STATUS_BRAKE);
                pedal_nxt = (in_rx_byte == STATUS_PEDAL);
                good      = 1'b1;
              end
              RQ_SPEED: begin
                good = (speed_sum == in_rx_byte);
                if (good) rpm_nxt = {reply_bytes_r[0], reply_bytes_r[1]};
              end
              RQ_CURRENT: begin
                good = (reply_bytes_r[0] == in_rx_byte);
                if (good) current_nxt = reply_bytes_r[0];
              end
              default: begin
                good = (reply_bytes_r[0] == in_rx_byte);
                if (good) battery_nxt = reply_bytes_r[0];
              end
            endcase
          end
        end
      end else begin
        time_now_nxt = time_inc;
        if (waiting_r) begin
          if (elapsed >= TIME_BITS'(timeout_r)) begin
            fin = 1'b1;
          end
        end else if (elapsed >= TIME_BITS'(interval_r)) begin
          round_nxt = round_r + 4'd1;
          case (round_r[1:0])
            2'd0, 2'd1: req_kind_nxt = RQ_STATUS;
            2'd2:       req_kind_nxt = RQ_SPEED;
            default:    req_kind_nxt = round_nxt[3] ? RQ_BATTERY : RQ_CURRENT;
          endcase
          last_poll_nxt = time_inc;
          waiting_nxt   = 1'b1;
          bytes_got_nxt = 2'd0;
          push_cnt      = 2'd2;
          beat0.kind    = KIND_TX;
          beat0.tx_byte = REQ_HEAD;
          beat1.kind    = KIND_TX;
          beat1.tx_byte = sel_byte(req_kind_nxt);
          beat1.last    = 1'b1;
        end
      end
    end

    if (fin) begin
      waiting_nxt   = 1'b0;
      bytes_got_nxt = 2'd0;
      if (good) begin
        reply_time_nxt = 32'(last_poll_r);
        link_nxt       = 1'b1;
        miss_nxt       = 8'd0;
      end else begin
        miss_nxt = miss_inc;
        if (miss_inc >= limit_r) link_nxt = 1'b0;
      end
      push_cnt                = 2'd1;
      beat0.kind              = KIND_REPORT;
      beat0.last              = 1'b1;
      beat0.ok                = good;
      beat0.brake             = brake_nxt;
      beat0.pedaling          = pedal_nxt;
      beat0.current_half_amps = current_nxt;
      beat0.wheel_rpm         = rpm_nxt;
      beat0.battery_pct       = battery_nxt;
      beat0.link_up           = link_nxt;
      beat0.last_reply_time   = reply_time_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r   <= RST_POLL_INTERVAL;
      timeout_r    <= RST_REPLY_TIMEOUT;
      limit_r      <= RST_MISS_LIMIT;
      time_now_r   <= '0;
      last_poll_r  <= '0;
      round_r      <= '0;
      miss_r       <= '0;
      waiting_r    <= 1'b0;
      req_kind_r   <= RQ_STATUS;
      bytes_got_r  <= '0;
      brake_r      <= 1'b0;
      pedal_r      <= 1'b0;
      current_r    <= '0;
      rpm_r        <= '0;
      battery_r    <= '0;
      link_r       <= 1'b0;
      reply_time_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_POLL_INTERVAL: interval_r <= cfg_wdata;
          CFG_REPLY_TIMEOUT: timeout_r  <= cfg_wdata;
          CFG_MISS_LIMIT:    limit_r    <= cfg_wdata[7:0];
          default: ;
        endcase
      end
      time_now_r   <= time_now_nxt;
      last_poll_r  <= last_poll_nxt;
      round_r      <= round_nxt;
      miss_r       <= miss_nxt;
      waiting_r    <= waiting_nxt;
      req_kind_r   <= req_kind_nxt;
      bytes_got_r  <= bytes_got_nxt;
      brake_r      <= brake_nxt;
      pedal_r      <= pedal_nxt;
      current_r    <= current_nxt;
      rpm_r        <= rpm_nxt;
      battery_r    <= battery_nxt;
      link_r       <= link_nxt;
      reply_time_r <= reply_time_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rb_we) reply_bytes_r[bytes_got_r[0]] <= in_rx_byte;
  end

endmodule

// ===== rtl/mlpm_out_fifo.sv =====
// Result queue: takes up to two beats per cycle, delivers one beat per cycle while out_stall is low.
module mlpm_out_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [1:0]      push_cnt,
  input  mlpm_pkg::beat_t beat0,
  input  mlpm_pkg::beat_t beat1,
  output logic            room,
  output logic            out_valid,
  input  logic            out_stall,
  output mlpm_pkg::beat_t out_beat
);
  import mlpm_pkg::*;

  beat_t                 slot_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0] count_r, count_nxt;
  logic                  pop;

  assign out_valid = (count_r != '0);
  assign out_beat  = slot_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  assign room      = (count_r <= FIFO_CNT_W'(FIFO_DEPTH - 2));
  assign count_nxt = count_r + FIFO_CNT_W'(push_cnt) - FIFO_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + FIFO_PTR_W'(push_cnt);
      rd_ptr_r <= rd_ptr_r + FIFO_PTR_W'(pop);
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) slot_r[wr_ptr_r] <= beat0;
    if (push_cnt == 2'd2) slot_r[wr_ptr_r + FIFO_PTR_W'(1)] <= beat1;
  end

endmodule

// ===== rtl/motor_link_poll_master.sv =====
// Top level of the motor link poll master: core state machine plus result queue.
// Accepts one item (millisecond tick or received byte) per clock. All state for
// an item is updated in its accept cycle, and its result beats (none, one report,
// or two request bytes) enter a four-beat queue and are offered from the next
// cycle, one beat per unstalled clock. in_stall rises while under two slots are
// free, so sustained input rate is set only by how fast the result side drains.
module motor_link_poll_master #(
  parameter int TIME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  out_tx_byte,
  output logic        out_last,
  output logic        out_ok,
  output logic        out_brake,
  output logic        out_pedaling,
  output logic [7:0]  out_current_half_amps,
  output logic [15:0] out_wheel_rpm,
  output logic [7:0]  out_battery_pct,
  output logic        out_link_up,
  output logic [31:0] out_last_reply_time,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import mlpm_pkg::*;

  logic       room, step_en;
  logic [1:0] push_cnt;
  beat_t      beat0, beat1, out_beat;

  assign in_stall = !room;
  assign step_en  = in_valid && room;

  mlpm_core #(.TIME_BITS(TIME_BITS)) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (step_en),
    .in_cmd     (in_cmd),
    .in_rx_byte (in_rx_byte),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .push_cnt   (push_cnt),
    .beat0      (beat0),
    .beat1      (beat1)
  );

  mlpm_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .beat0     (beat0),
    .beat1     (beat1),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  assign out_kind              = out_beat.kind;
  assign out_tx_byte           = out_beat.tx_byte;
  assign out_last              = out_beat.last;
  assign out_ok                = out_beat.ok;
  assign out_brake             = out_beat.brake;
  assign out_pedaling          = out_beat.pedaling;
  assign out_current_half_amps = out_beat.current_half_amps;
  assign out_wheel_rpm         = out_beat.wheel_rpm;
  assign out_battery_pct       = out_beat.battery_pct;
  assign out_link_up           = out_beat.link_up;
  assign out_last_reply_time   = out_beat.last_reply_time;

endmodule
